// File: hw/rtl/uqps_pkg.sv
// Shared phase codes, result kinds and delimiter characters for the URL query splitter.
package uqps_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ByteW  = 8;

  typedef logic [PhaseW-1:0] phase_t;
  typedef logic [KindW-1:0]  kind_t;
  typedef logic [ByteW-1:0]  char_t;

  // parse phases
  localparam phase_t PH_SEEK      = 3'd0;
  localparam phase_t PH_KEY_EMPTY = 3'd1;
  localparam phase_t PH_KEY       = 3'd2;
  localparam phase_t PH_VAL       = 3'd3;
  localparam phase_t PH_VAL_DROP  = 3'd4;
  localparam phase_t PH_DONE      = 3'd5;

  // result kinds
  localparam kind_t KIND_KEY  = 2'd0;
  localparam kind_t KIND_VAL  = 2'd1;
  localparam kind_t KIND_PAIR = 2'd2;
  localparam kind_t KIND_URL  = 2'd3;

  localparam char_t CH_QUERY = 8'h3F; // '?'
  localparam char_t CH_HASH  = 8'h23; // '#'
  localparam char_t CH_AMP   = 8'h26; // '&'
  localparam char_t CH_EQ    = 8'h3D; // '='

endpackage

// File: hw/rtl/url_query_pair_splitter.sv
// Top level of the URL query splitter: phase tracking and result hold bank.
//
// Takes a URL one byte per word (tlast on its last byte) and emits the query's key bytes,
// value bytes, an end-of-pair word after each kept pair and an end-of-URL word after the
// last byte; tlast on the output marks the last word caused by one input byte. Each input
// byte is decoded combinationally against the current parse phase and its results (at most
// a text byte, an end of pair and an end of URL) are loaded into a three-slot hold bank.
// The bank drains one word per cycle, so a byte yielding zero or one word is taken every
// cycle when the sink is ready; a byte yielding more words holds off the next byte until its
// last word leaves the bank. There is no start-up sweep: the block is ready the cycle after reset.
module url_query_pair_splitter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  uqps_pkg::char_t      in_tdata,   // [7:0] url_byte
  input  logic                 in_tlast,   // final_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output uqps_pkg::char_t      out_tdata,  // [7:0] text_byte
  output uqps_pkg::kind_t      out_tuser,  // [1:0] item_kind
  output logic                 out_tlast   // run_last
);
  import uqps_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic  [2:0] slot_v_r, slot_v_nxt;   // [0] text word, [1] end of pair, [2] end of URL
  char_t       byte_r;
  kind_t       kind_r;

  logic        in_acc, out_acc;
  logic        emit_text, emit_pair, emit_url;
  kind_t       text_kind;
  phase_t      ph_step;
  logic  [2:0] slot_v_pop;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // bank must be empty after this cycle before a new byte may load it
  assign in_tready = (slot_v_r == 3'b000) || ($onehot(slot_v_r) && out_tready);

  // character decode against the current phase
  always_comb begin
    ph_step   = phase_r;
    emit_text = 1'b0;
    emit_pair = 1'b0;
    text_kind = KIND_KEY;
    case (phase_r)
      PH_SEEK: begin
        if (in_tdata == CH_QUERY) ph_step = PH_KEY_EMPTY;
        else if (in_tdata == CH_HASH) ph_step = PH_DONE;
      end
      PH_KEY_EMPTY: begin
        if (in_tdata == CH_AMP) ph_step = PH_KEY_EMPTY;
        else if (in_tdata == CH_EQ) ph_step = PH_VAL_DROP;
        else if (in_tdata == CH_HASH) ph_step = PH_DONE;
        else begin
          emit_text = 1'b1;
          ph_step   = PH_KEY;
        end
      end
      PH_KEY: begin
        if (in_tdata == CH_AMP) begin
          emit_pair = 1'b1;
          ph_step   = PH_KEY_EMPTY;
        end else if (in_tdata == CH_EQ) begin
          ph_step = PH_VAL;
        end else if (in_tdata == CH_HASH) begin
          emit_pair = 1'b1;
          ph_step   = PH_DONE;
        end else begin
          emit_text = 1'b1;
        end
      end
      PH_VAL: begin
        if (in_tdata == CH_AMP) begin
          emit_pair = 1'b1;
          ph_step   = PH_KEY_EMPTY;
        end else if (in_tdata == CH_HASH) begin
          emit_pair = 1'b1;
          ph_step   = PH_DONE;
        end else begin
          emit_text = 1'b1;
          text_kind = KIND_VAL;
        end
      end
      PH_VAL_DROP: begin
        if (in_tdata == CH_AMP) ph_step = PH_KEY_EMPTY;
        else if (in_tdata == CH_HASH) ph_step = PH_DONE;
      end
      default: ph_step = PH_DONE;
    endcase

    // last byte closes any open pair, then the URL
    emit_url  = in_tlast;
    phase_nxt = ph_step;
    if (in_tlast) begin
      if (ph_step == PH_KEY || ph_step == PH_VAL) emit_pair = 1'b1;
      phase_nxt = PH_SEEK;
    end
  end

  // drop the lowest occupied slot once its word is taken
  always_comb begin
    slot_v_pop = slot_v_r;
    if (out_acc) begin
      if (slot_v_r[0]) slot_v_pop[0] = 1'b0;
      else if (slot_v_r[1]) slot_v_pop[1] = 1'b0;
      else slot_v_pop[2] = 1'b0;
    end
    slot_v_nxt = in_acc ? {emit_url, emit_pair, emit_text} : slot_v_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEEK;
      slot_v_r <= 3'b000;
    end else begin
      slot_v_r <= slot_v_nxt;
      if (in_acc) phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit_text) begin
      byte_r <= in_tdata;
      kind_r <= text_kind;
    end
  end

  assign out_tvalid = slot_v_r != 3'b000;
  assign out_tlast  = $onehot(slot_v_r);
  always_comb begin
    if (slot_v_r[0]) begin
      out_tdata = byte_r;
      out_tuser = kind_r;
    end else if (slot_v_r[1]) begin
      out_tdata = '0;
      out_tuser = KIND_PAIR;
    end else begin
      out_tdata = '0;
      out_tuser = KIND_URL;
    end
  end

  // phase never reaches the unused codes
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DONE)
    else $error("parse phase out of range");

  // a held text word is always a key or value byte
  a_text_kind: assert property (@(posedge clk) disable iff (!rst_n)
    slot_v_r[0] |-> (kind_r == KIND_KEY || kind_r == KIND_VAL))
    else $error("text slot holds a marker kind");

  // last byte always queues an end of URL and rearms the parser
  a_url_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (slot_v_r[2] && phase_r == PH_SEEK))
    else $error("end of URL not queued");

  // a new byte is only taken when the bank drains this cycle
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (slot_v_r == 3'b000 || ($onehot(slot_v_r) && out_acc)))
    else $error("hold bank overrun");

endmodule

// File: sim/url_query_pair_splitter_checker.sv
// Checker for the URL query splitter: predicts result words from accepted bytes and compares.
module url_query_pair_splitter_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  uqps_pkg::char_t in_tdata,
  input  logic            in_tlast,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  uqps_pkg::char_t out_tdata,
  input  uqps_pkg::kind_t out_tuser,
  input  logic            out_tlast,
  output int unsigned     pending,
  output int unsigned     fail_count
);
  import uqps_pkg::*;

  typedef struct packed {
    char_t text;
    kind_t kind;
    logic  run_last;
  } split_word_t;

  split_word_t expected_words[$];
  phase_t      query_phase;
  split_word_t want;
  split_word_t seen;

  function automatic split_word_t split_word(input char_t text, input kind_t kind);
    return split_word_t'({text, kind, 1'b0});
  endfunction

  // Advance the parse phase by one URL byte and queue the words it should produce.
  task automatic split_byte(input char_t c, input logic fin);
    split_word_t words[$];
    phase_t      ph;
    ph = query_phase;
    case (ph)
      PH_SEEK: begin
        if (c == CH_QUERY) ph = PH_KEY_EMPTY;
        else if (c == CH_HASH) ph = PH_DONE;
      end
      PH_KEY_EMPTY: begin
        if (c == CH_EQ) ph = PH_VAL_DROP;
        else if (c == CH_HASH) ph = PH_DONE;
        else if (c != CH_AMP) begin
          words.push_back(split_word(c, KIND_KEY));
          ph = PH_KEY;
        end
      end
      PH_KEY: begin
        if (c == CH_AMP) begin
          words.push_back(split_word('0, KIND_PAIR));
          ph = PH_KEY_EMPTY;
        end else if (c == CH_EQ) begin
          ph = PH_VAL;
        end else if (c == CH_HASH) begin
          words.push_back(split_word('0, KIND_PAIR));
          ph = PH_DONE;
        end else begin
          words.push_back(split_word(c, KIND_KEY));
        end
      end
      PH_VAL: begin
        if (c == CH_AMP) begin
          words.push_back(split_word('0, KIND_PAIR));
          ph = PH_KEY_EMPTY;
        end else if (c == CH_HASH) begin
          words.push_back(split_word('0, KIND_PAIR));
          ph = PH_DONE;
        end else begin
          words.push_back(split_word(c, KIND_VAL));
        end
      end
      PH_VAL_DROP: begin
        if (c == CH_AMP) ph = PH_KEY_EMPTY;
        else if (c == CH_HASH) ph = PH_DONE;
      end
      default: ph = PH_DONE;
    endcase
    if (fin) begin
      // an open pair is closed before the end-of-URL word
      if (ph == PH_KEY || ph == PH_VAL) words.push_back(split_word('0, KIND_PAIR));
      words.push_back(split_word('0, KIND_URL));
      ph = PH_SEEK;
    end
    if (words.size() > 0) words[words.size()-1].run_last = 1'b1;
    foreach (words[i]) expected_words.push_back(words[i]);
    query_phase = ph;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      query_phase = PH_SEEK;
      expected_words.delete();
      fail_count = 0;
    end else begin
      // predict first: a word leaving this edge is always older than the byte entering
      if (in_tvalid && in_tready) split_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen = split_word_t'({out_tdata, out_tuser, out_tlast});
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual text %02h kind %0d last %0b",
                   $time, seen.text, seen.kind, seen.run_last);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (seen.text !== want.text || seen.kind !== want.kind
              || seen.run_last !== want.run_last) begin
            $display("%0t: mismatch: expected text %02h kind %0d last %0b,",
                     $time, want.text, want.kind, want.run_last,
                     " actual text %02h kind %0d last %0b",
                     seen.text, seen.kind, seen.run_last);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

// File: sim/url_query_pair_splitter_tb.sv
// Testbench top for the URL query splitter: clock, reset, URL stimulus, sink stalls and verdict.
module url_query_pair_splitter_tb;
  import uqps_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned RandomBytes = 130;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  char_t       in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  char_t       out_tdata;
  kind_t       out_tuser;
  logic        out_tlast;
  int unsigned pending;
  int unsigned fail_count;

  char_t       url_bytes[$];
  int unsigned burst_left;
  int unsigned quiet_cycles;
  int unsigned bytes_sent;

  url_query_pair_splitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  url_query_pair_splitter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sink readiness: stretches of fixed odds, from solid stall to always ready
  initial begin : sink_pattern
    int unsigned span;
    int unsigned ready_odds;
    out_tready = 1'b0;
    forever begin
      span       = $urandom_range(4, 24);
      ready_odds = $urandom_range(0, 4) * 25;
      repeat (span) begin
        @(negedge clk);
        out_tready <= ($urandom_range(1, 100) <= ready_odds);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tdata  <= char_t'($urandom_range(0, 255));
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_byte(input char_t b, input logic fin);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      hold_off($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_url();
    bytes_sent += url_bytes.size();
    foreach (url_bytes[i]) send_byte(url_bytes[i], i == url_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly lower-case letters, now and then any byte at all
  function automatic char_t text_char();
    if ($urandom_range(0, 7) == 0) return char_t'($urandom_range(0, 255));
    return char_t'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void build_query_url();
    int unsigned segs;
    url_bytes.delete();
    repeat ($urandom_range(0, 6)) url_bytes.push_back(text_char());
    // sometimes a fragment comes before any query
    url_bytes.push_back(($urandom_range(0, 9) == 0) ? CH_HASH : CH_QUERY);
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      if (s > 0) url_bytes.push_back(CH_AMP);
      repeat ($urandom_range(0, 3)) url_bytes.push_back(text_char());
      if ($urandom_range(0, 3) != 0) begin
        url_bytes.push_back(CH_EQ);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 5))
            0:       url_bytes.push_back(CH_EQ);
            1:       url_bytes.push_back(CH_QUERY);
            default: url_bytes.push_back(text_char());
          endcase
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      url_bytes.push_back(CH_HASH);
      repeat ($urandom_range(0, 3)) url_bytes.push_back(text_char());
    end
  endfunction

  function automatic void build_noise_url();
    url_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 5))
        0:       url_bytes.push_back(CH_QUERY);
        1:       url_bytes.push_back(CH_HASH);
        2:       url_bytes.push_back(CH_AMP);
        3:       url_bytes.push_back(CH_EQ);
        default: url_bytes.push_back(char_t'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // fragment before the query: everything after is skipped
    url_bytes = '{8'h00, CH_HASH, CH_QUERY, 8'h6B, 8'h5A};
    send_url();
    // repeated marks inside a value, empty segment, empty key, key alone, fragment end
    url_bytes = '{CH_QUERY, 8'h61, CH_EQ, CH_QUERY, CH_EQ, CH_AMP, CH_AMP, CH_EQ, 8'h78,
                  CH_AMP, 8'h62, CH_HASH, 8'h63, 8'hFF};
    send_url();
    // last byte inside a value: text, end of pair and end of URL from one byte
    url_bytes = '{CH_QUERY, 8'h6B, CH_EQ, 8'hFF};
    send_url();
    // single-byte URL ending while still seeking
    url_bytes = '{8'h80};
    send_url();
    wait_drained();

    while (bytes_sent < RandomBytes) begin
      if ($urandom_range(0, 4) == 0) build_noise_url();
      else build_query_url();
      send_url();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
